@@ sv/ppbp_pkg.sv @@
// ----------------------------------------------------------------------------
// ppbp_pkg
// Shared types, constants and pixel helpers for the particle pool plotter.
// ----------------------------------------------------------------------------
package ppbp_pkg;

   localparam int LINK_W = 7;

   typedef logic [LINK_W-1:0] link_type;

   localparam link_type LINK_NULL = 7'd127;

   // on-screen limits in 10.6 fixed point
   localparam logic [15:0] X_LIMIT = 16'd20480;   // 320 * 64
   localparam logic [15:0] Y_LIMIT = 16'd12800;   // 200 * 64

   localparam logic [7:0] SET_MASKS [4] = '{8'hc0, 8'h30, 8'h0c, 8'h03};
   localparam logic [7:0] CLR_MASKS [4] = '{8'h3f, 8'hcf, 8'hf3, 8'hfc};

   typedef struct packed {
      logic [7:0]  pattern;
      logic [15:0] vel_y;
      logic [15:0] vel_x;
      logic [15:0] pos_y;
      logic [15:0] pos_x;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic     we;
      link_type waddr;
      link_type wdata;
      logic     re;
      link_type raddr;
   } link_req_type;

   typedef struct packed {
      logic     we;
      link_type waddr;
      slot_type wdata;
      logic     re;
      link_type raddr;
   } slot_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_EVAL,
      ST_EMIT,
      ST_UNLINK
   } state_type;

   function automatic logic on_screen(logic [15:0] x, logic [15:0] y);
      return !x[15] && (x < X_LIMIT) && !y[15] && (y < Y_LIMIT);
   endfunction

   // 320*(py>>3) + (px & ~7) + (py & 6), with px = x>>6 and py = y>>6
   function automatic logic [12:0] pix_addr(logic [15:0] x, logic [15:0] y);
      logic [15:0] sum;
      sum = {1'b0, y[15:9], 8'b0} + {3'b0, y[15:9], 6'b0}
          + {6'b0, x[15:9], 3'b0} + {13'b0, y[8:7], 1'b0};
      return sum[12:0];
   endfunction

endpackage

@@ sv/ppbp_req_if.sv @@
// ----------------------------------------------------------------------------
// ppbp_req_if
// Request channel: add a particle or run one animation tick.
// ----------------------------------------------------------------------------
interface ppbp_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic [7:0]         pattern;

   modport source (output valid, action, pos_x, pos_y, vel_x, vel_y, pattern,
                   input ready);
   modport sink   (input valid, action, pos_x, pos_y, vel_x, vel_y, pattern,
                   output ready);
endinterface

@@ sv/ppbp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ppbp_rsp_if
// Response channel: one clear/set bitmap update per live particle.
// ----------------------------------------------------------------------------
interface ppbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] clear_addr;
   logic [7:0]  clear_mask;
   logic        set_valid;
   logic [12:0] set_addr;
   logic [7:0]  set_bits;
   logic        last;

   modport source (output valid, clear_addr, clear_mask, set_valid, set_addr,
                   set_bits, last, input ready);
   modport sink   (input valid, clear_addr, clear_mask, set_valid, set_addr,
                   set_bits, last, output ready);
endinterface

@@ sv/ppbp_ram.sv @@
// ----------------------------------------------------------------------------
// ppbp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ppbp_link_store.sv @@
// ----------------------------------------------------------------------------
// ppbp_link_store
// Slot link memory; unwritten entries read as the initial free chain.
// ----------------------------------------------------------------------------
module ppbp_link_store #(
   parameter int MAX_PARTICLES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ppbp_pkg::link_req_type req,
   output ppbp_pkg::link_type     rd_link
);

   localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

   logic [MAX_PARTICLES-1:0] written_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic                     rd_written_ff;
   ppbp_pkg::link_type       ram_data;

   function automatic ppbp_pkg::link_type chain_link(logic [IDX_W-1:0] idx);
      logic [7:0] n;
      n = 8'(idx) + 8'd1;
      return (n < 8'(MAX_PARTICLES)) ? n[6:0] : ppbp_pkg::LINK_NULL;
   endfunction

   ppbp_ram #(
      .WIDTH (ppbp_pkg::LINK_W),
      .DEPTH (MAX_PARTICLES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (req.we),
      .wr_addr (req.waddr[IDX_W-1:0]),
      .wr_data (req.wdata),
      .rd_en   (req.re),
      .rd_addr (req.raddr[IDX_W-1:0]),
      .rd_data (ram_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (req.we) begin
         written_ff[req.waddr[IDX_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.re) begin
         rd_idx_ff     <= req.raddr[IDX_W-1:0];
         rd_written_ff <= written_ff[req.raddr[IDX_W-1:0]];
      end
   end

   assign rd_link = rd_written_ff ? ram_data : chain_link(rd_idx_ff);

endmodule

@@ sv/ppbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppbp_ctrl
// Pool sequencer: add, list walk, particle update and response register.
// ----------------------------------------------------------------------------
module ppbp_ctrl #(
   parameter int MAX_PARTICLES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             gravity,
   ppbp_req_if.sink               req,
   ppbp_rsp_if.source             rsp,
   output ppbp_pkg::link_req_type link_req,
   input  ppbp_pkg::link_type     link_rd,
   output ppbp_pkg::slot_req_type slot_req,
   input  ppbp_pkg::slot_type     slot_rd
);

   localparam int VIS_W = $clog2(MAX_PARTICLES + 1);

   ppbp_pkg::state_type state_ff, state_in;
   ppbp_pkg::link_type  free_head_ff, free_head_in;
   ppbp_pkg::link_type  used_head_ff, used_head_in;
   ppbp_pkg::link_type  cur_ff, cur_in;
   ppbp_pkg::link_type  prev_ff, prev_in;
   ppbp_pkg::link_type  next_ff, next_in;
   logic [VIS_W-1:0]    visits_ff, visits_in;
   logic                end_ff, end_in;

   logic [12:0] clr_addr_ff, clr_addr_in;
   logic [7:0]  clr_mask_ff, clr_mask_in;
   logic [15:0] nx_ff, nx_in;
   logic [15:0] ny_ff, ny_in;
   logic [7:0]  pat_ff, pat_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [12:0] rsp_clear_addr_ff, rsp_clear_addr_in;
   logic [7:0]  rsp_clear_mask_ff, rsp_clear_mask_in;
   logic        rsp_set_valid_ff, rsp_set_valid_in;
   logic [12:0] rsp_set_addr_ff, rsp_set_addr_in;
   logic [7:0]  rsp_set_bits_ff, rsp_set_bits_in;
   logic        rsp_last_ff, rsp_last_in;

   logic             req_fire;
   logic             add_ok;
   logic             tick_ok;
   logic             out_free;
   logic             set_ok;
   logic             prev_ok;
   logic [VIS_W-1:0] vis_inc;
   logic             last_w;
   logic [15:0]      grav16;

   function automatic logic slot_ok(ppbp_pkg::link_type s);
      return s < ppbp_pkg::LINK_W'(MAX_PARTICLES);
   endfunction

   assign grav16   = {{8{gravity[7]}}, gravity};
   assign req_fire = req.valid && (state_ff == ppbp_pkg::ST_IDLE);
   assign add_ok   = slot_ok(free_head_ff)
                     && ppbp_pkg::on_screen(req.pos_x, req.pos_y);
   assign tick_ok  = slot_ok(used_head_ff);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign set_ok   = ppbp_pkg::on_screen(nx_ff, ny_ff);
   assign prev_ok  = slot_ok(prev_ff);
   assign vis_inc  = visits_ff + 1'b1;
   assign last_w   = !slot_ok(next_ff) || (vis_inc == VIS_W'(MAX_PARTICLES));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppbp_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (!req.action && add_ok) begin
                  state_in = ppbp_pkg::ST_ADD;
               end else if (req.action && tick_ok) begin
                  state_in = ppbp_pkg::ST_EVAL;
               end
            end
         end
         ppbp_pkg::ST_ADD: begin
            state_in = ppbp_pkg::ST_IDLE;
         end
         ppbp_pkg::ST_EVAL: begin
            state_in = ppbp_pkg::ST_EMIT;
         end
         ppbp_pkg::ST_EMIT: begin
            if (out_free) begin
               if (!set_ok && prev_ok) begin
                  state_in = ppbp_pkg::ST_UNLINK;
               end else if (last_w) begin
                  state_in = ppbp_pkg::ST_IDLE;
               end else begin
                  state_in = ppbp_pkg::ST_EVAL;
               end
            end
         end
         ppbp_pkg::ST_UNLINK: begin
            state_in = end_ff ? ppbp_pkg::ST_IDLE : ppbp_pkg::ST_EVAL;
         end
         default: begin
            state_in = ppbp_pkg::ST_IDLE;
         end
      endcase
   end

   // register updates and memory requests
   always_comb begin
      free_head_in      = free_head_ff;
      used_head_in      = used_head_ff;
      cur_in            = cur_ff;
      prev_in           = prev_ff;
      next_in           = next_ff;
      visits_in         = visits_ff;
      end_in            = end_ff;
      clr_addr_in       = clr_addr_ff;
      clr_mask_in       = clr_mask_ff;
      nx_in             = nx_ff;
      ny_in             = ny_ff;
      pat_in            = pat_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp.ready;
      rsp_clear_addr_in = rsp_clear_addr_ff;
      rsp_clear_mask_in = rsp_clear_mask_ff;
      rsp_set_valid_in  = rsp_set_valid_ff;
      rsp_set_addr_in   = rsp_set_addr_ff;
      rsp_set_bits_in   = rsp_set_bits_ff;
      rsp_last_in       = rsp_last_ff;
      link_req          = '0;
      slot_req          = '0;

      unique case (state_ff)
         ppbp_pkg::ST_IDLE: begin
            if (req_fire && !req.action && add_ok) begin
               cur_in                 = free_head_ff;
               link_req.re            = 1'b1;
               link_req.raddr         = free_head_ff;
               slot_req.we            = 1'b1;
               slot_req.waddr         = free_head_ff;
               slot_req.wdata.pos_x   = req.pos_x;
               slot_req.wdata.pos_y   = req.pos_y;
               slot_req.wdata.vel_x   = req.vel_x;
               slot_req.wdata.vel_y   = req.vel_y;
               slot_req.wdata.pattern = req.pattern;
            end else if (req_fire && req.action && tick_ok) begin
               cur_in         = used_head_ff;
               prev_in        = ppbp_pkg::LINK_NULL;
               visits_in      = '0;
               link_req.re    = 1'b1;
               link_req.raddr = used_head_ff;
               slot_req.re    = 1'b1;
               slot_req.raddr = used_head_ff;
            end
         end
         ppbp_pkg::ST_ADD: begin
            // new slot goes to the head of the used list
            free_head_in   = link_rd;
            used_head_in   = cur_ff;
            link_req.we    = 1'b1;
            link_req.waddr = cur_ff;
            link_req.wdata = used_head_ff;
         end
         ppbp_pkg::ST_EVAL: begin
            next_in     = link_rd;
            clr_addr_in = ppbp_pkg::pix_addr(slot_rd.pos_x, slot_rd.pos_y);
            clr_mask_in = ppbp_pkg::CLR_MASKS[slot_rd.pos_x[8:7]];
            nx_in       = slot_rd.pos_x + slot_rd.vel_x;
            ny_in       = slot_rd.pos_y + slot_rd.vel_y;
            pat_in      = slot_rd.pattern;
            slot_req.we            = 1'b1;
            slot_req.waddr         = cur_ff;
            slot_req.wdata.pos_x   = nx_in;
            slot_req.wdata.pos_y   = ny_in;
            slot_req.wdata.vel_x   = slot_rd.vel_x;
            slot_req.wdata.vel_y   = slot_rd.vel_y + grav16;
            slot_req.wdata.pattern = slot_rd.pattern;
         end
         ppbp_pkg::ST_EMIT: begin
            if (out_free) begin
               visits_in         = vis_inc;
               end_in            = last_w;
               rsp_valid_in      = 1'b1;
               rsp_clear_addr_in = clr_addr_ff;
               rsp_clear_mask_in = clr_mask_ff;
               rsp_set_valid_in  = set_ok;
               rsp_set_addr_in   = set_ok ? ppbp_pkg::pix_addr(nx_ff, ny_ff) : 13'd0;
               rsp_set_bits_in   = set_ok ? (ppbp_pkg::SET_MASKS[nx_ff[8:7]] & pat_ff)
                                          : 8'd0;
               rsp_last_in       = last_w;
               if (set_ok) begin
                  prev_in = cur_ff;
               end else begin
                  // particle left the screen: back to the free list
                  free_head_in   = cur_ff;
                  link_req.we    = 1'b1;
                  link_req.waddr = cur_ff;
                  link_req.wdata = free_head_ff;
                  if (!prev_ok) begin
                     used_head_in = next_ff;
                  end
               end
               if ((set_ok || !prev_ok) && !last_w) begin
                  cur_in         = next_ff;
                  link_req.re    = 1'b1;
                  link_req.raddr = next_ff;
                  slot_req.re    = 1'b1;
                  slot_req.raddr = next_ff;
               end
            end
         end
         ppbp_pkg::ST_UNLINK: begin
            link_req.we    = 1'b1;
            link_req.waddr = prev_ff;
            link_req.wdata = next_ff;
            if (!end_ff) begin
               cur_in         = next_ff;
               link_req.re    = 1'b1;
               link_req.raddr = next_ff;
               slot_req.re    = 1'b1;
               slot_req.raddr = next_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppbp_pkg::ST_IDLE;
         free_head_ff <= '0;
         used_head_ff <= ppbp_pkg::LINK_NULL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         used_head_ff <= used_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff            <= cur_in;
      prev_ff           <= prev_in;
      next_ff           <= next_in;
      visits_ff         <= visits_in;
      end_ff            <= end_in;
      clr_addr_ff       <= clr_addr_in;
      clr_mask_ff       <= clr_mask_in;
      nx_ff             <= nx_in;
      ny_ff             <= ny_in;
      pat_ff            <= pat_in;
      rsp_clear_addr_ff <= rsp_clear_addr_in;
      rsp_clear_mask_ff <= rsp_clear_mask_in;
      rsp_set_valid_ff  <= rsp_set_valid_in;
      rsp_set_addr_ff   <= rsp_set_addr_in;
      rsp_set_bits_ff   <= rsp_set_bits_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign req.ready      = (state_ff == ppbp_pkg::ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.clear_addr = rsp_clear_addr_ff;
   assign rsp.clear_mask = rsp_clear_mask_ff;
   assign rsp.set_valid  = rsp_set_valid_ff;
   assign rsp.set_addr   = rsp_set_addr_ff;
   assign rsp.set_bits   = rsp_set_bits_ff;
   assign rsp.last       = rsp_last_ff;

   // the two list heads never name the same slot
   a_heads_apart: assert property (@(posedge clock) disable iff (reset)
      (slot_ok(used_head_ff) && slot_ok(free_head_ff)) |-> used_head_ff != free_head_ff)
      else $error("used and free list heads coincide");

   // a walk works only on a real slot
   a_cur_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppbp_pkg::ST_EVAL || state_ff == ppbp_pkg::ST_EMIT) |-> slot_ok(cur_ff))
      else $error("walk on an invalid slot");

   // the walk never passes the pool size
   a_visit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppbp_pkg::ST_EMIT) |-> visits_ff < VIS_W'(MAX_PARTICLES))
      else $error("walk visited too many slots");

   // freed particle carries no set update
   a_freed_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_set_valid_ff) |-> (rsp_set_addr_ff == 13'd0
                                             && rsp_set_bits_ff == 8'd0))
      else $error("freed particle with set bits");

   // an unlink returns to idle or goes on to the next particle
   a_unlink_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppbp_pkg::ST_UNLINK) |=> (state_ff == ppbp_pkg::ST_IDLE
                                          || state_ff == ppbp_pkg::ST_EVAL))
      else $error("unlink not followed by idle or next particle");

endmodule

@@ sv/particle_pool_bitmap_plotter.sv @@
// ----------------------------------------------------------------------------
// particle_pool_bitmap_plotter
// Particle pool with bitmap clear/set updates per animation tick.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   action, pos_x, pos_y, vel_x, vel_y, pattern
//  rsp      out  valid/ready   clear_addr, clear_mask, set_valid, set_addr,
//                              set_bits, last
//  csr      in   csr_wr_en     csr_wr_data (gravity)
//
//  an add reads the free head's link, then links the slot into the used list;
//  a tick walks the used list with an evaluate and an emit step per live
//  particle, plus an unlink step for a freed particle with a newer neighbour;
//  slot and link memory reads are registered; an empty tick gives no response
//  reset is synchronous; the pool comes up empty, gravity 8, no clearing pass
//  a new request is taken only when the sequencer is idle; a stalled response
//  holds the walk at its current particle
// ----------------------------------------------------------------------------
module particle_pool_bitmap_plotter #(
   parameter int MAX_PARTICLES = 64
) (
   input  logic       clock,
   input  logic       reset,
   ppbp_req_if.sink   req,
   ppbp_rsp_if.source rsp,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

   logic [7:0]             gravity_ff, gravity_in;
   ppbp_pkg::link_req_type link_req;
   ppbp_pkg::link_type     link_rd;
   ppbp_pkg::slot_req_type slot_req;
   ppbp_pkg::slot_type     slot_rd;

   assign gravity_in = csr_wr_en ? csr_wr_data : gravity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= 8'd8;
      end else begin
         gravity_ff <= gravity_in;
      end
   end

   ppbp_ram #(
      .WIDTH (ppbp_pkg::SLOT_W),
      .DEPTH (MAX_PARTICLES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_req.we),
      .wr_addr (slot_req.waddr[IDX_W-1:0]),
      .wr_data (slot_req.wdata),
      .rd_en   (slot_req.re),
      .rd_addr (slot_req.raddr[IDX_W-1:0]),
      .rd_data (slot_rd)
   );

   ppbp_link_store #(
      .MAX_PARTICLES (MAX_PARTICLES)
   ) u_link_store (
      .clock   (clock),
      .reset   (reset),
      .req     (link_req),
      .rd_link (link_rd)
   );

   ppbp_ctrl #(
      .MAX_PARTICLES (MAX_PARTICLES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .gravity  (gravity_ff),
      .req      (req),
      .rsp      (rsp),
      .link_req (link_req),
      .link_rd  (link_rd),
      .slot_req (slot_req),
      .slot_rd  (slot_rd)
   );

endmodule
